### hw/rtl/vps_pkg.sv
// Package for the vertex projection block: payload structs, configuration
// struct, register index codes and fixed arithmetic widths. No dependencies.
`timescale 1ns / 1ps

package vps_pkg;

  localparam int unsigned PROD_W   = 48;
  localparam int unsigned SUM_W    = 50;
  localparam int unsigned CLIP_W   = 38;
  localparam int unsigned NUM_W    = 39;
  localparam int unsigned SPAN_W   = 14;
  localparam int unsigned N_W      = 53;
  localparam int unsigned DIV_BITS = 31;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_ROW_W  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic               on_screen;
    logic               w_zero;
  } out_item_t;

  typedef struct packed {
    logic [3:0][CFG_W-1:0] row;
    logic [SPAN_W-1:0]     width;
    logic [SPAN_W-1:0]     height;
  } cfg_t;

  typedef struct packed {
    logic [CLIP_W-1:0]  d;
    logic [N_W-1:0]     n_x;
    logic [N_W-1:0]     n_y;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] depth;
    logic               w_zero;
  } work_t;

endpackage

### hw/rtl/vps_front.sv
// Front part: matrix product, clip rounding, numerator forming and span scaling.
// Depends on vps_pkg.
`timescale 1ns / 1ps

module vps_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vps_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  vps_pkg::in_item_t in_i,
  output logic              in_stall_o,
  output logic              push_o,
  output vps_pkg::work_t    item_o,
  input  logic              full_i
);

  localparam int unsigned PW  = vps_pkg::PROD_W;
  localparam int unsigned SW  = vps_pkg::SUM_W;
  localparam int unsigned CW  = vps_pkg::CLIP_W;
  localparam int unsigned NW  = vps_pkg::NUM_W;
  localparam int unsigned NNW = vps_pkg::N_W;

  logic [2:0] v_q;
  logic       adv;

  logic signed [PW-1:0] prod_q [4][3];
  logic signed [15:0]   c3_q   [4];
  logic signed [SW-1:0] sum_d  [4];
  logic signed [CW-1:0] clip_q [4];

  logic signed [31:0] pt [3];

  logic signed [NW-1:0] num_x, num_y;
  logic signed [CW-1:0] cz, cw;
  logic [NW-1:0]        abs_x_d, abs_y_d, abs_x_q, abs_y_q;
  logic [CW-1:0]        d_q, d_d;
  logic                 neg_x_d, neg_y_d, wz_d;
  logic                 neg_x_q, neg_y_q, wz_q;
  logic signed [31:0]   depth_q, depth_d;

  assign adv        = !(v_q[2] && full_i);
  assign in_stall_o = !adv;
  assign push_o     = v_q[2] && !full_i;

  assign pt[0] = in_i.point_x;
  assign pt[1] = in_i.point_y;
  assign pt[2] = in_i.point_z;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2])
               + (SW'(c3_q[r]) <<< 28);
    end
  end

  assign cz = clip_q[2];
  assign cw = clip_q[3];

  always_comb begin
    num_x   = NW'(clip_q[0]) + NW'(cw);
    num_y   = NW'(cw) - NW'(clip_q[1]);
    neg_x_d = num_x[NW-1] ^ cw[CW-1];
    neg_y_d = num_y[NW-1] ^ cw[CW-1];
    abs_x_d = num_x[NW-1] ? $unsigned(-num_x) : $unsigned(num_x);
    abs_y_d = num_y[NW-1] ? $unsigned(-num_y) : $unsigned(num_y);
    d_d     = cw[CW-1] ? $unsigned(-cw) : $unsigned(cw);
    wz_d    = (cw == '0);
    if (!cz[CW-1] && (cz[CW-2:31] != '0)) begin
      depth_d = 32'sh7fffffff;
    end else if (cz[CW-1] && (cz[CW-2:31] != '1)) begin
      depth_d = 32'sh80000000;
    end else begin
      depth_d = cz[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= PW'($signed(cfg_i.row[r][16*k +: 16])) * PW'(pt[k]);
        end
        c3_q[r]   <= $signed(cfg_i.row[r][63:48]);
        clip_q[r] <= sum_d[r][SW-1:12];
      end
      abs_x_q <= abs_x_d;
      abs_y_q <= abs_y_d;
      d_q     <= d_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
      wz_q    <= wz_d;
      depth_q <= depth_d;
    end
  end

  always_comb begin
    item_o.d      = d_q;
    item_o.n_x    = NNW'(abs_x_q) * NNW'(cfg_i.width);
    item_o.n_y    = NNW'(abs_y_q) * NNW'(cfg_i.height);
    item_o.neg_x  = neg_x_q;
    item_o.neg_y  = neg_y_q;
    item_o.depth  = depth_q;
    item_o.w_zero = wz_q;
  end

endmodule

### hw/rtl/vps_queue.sv
// Short queue between the front and back parts of the vertex projection block.
// Depends on vps_pkg.
`timescale 1ns / 1ps

module vps_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vps_pkg::work_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output vps_pkg::work_t item_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vps_pkg::work_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/vps_back.sv
// Back part: pipelined restoring divider for both screen axes and output register.
// Depends on vps_pkg.
`timescale 1ns / 1ps

module vps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vps_pkg::cfg_t      cfg_i,
  input  logic               empty_i,
  input  vps_pkg::work_t     item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output vps_pkg::out_item_t out_o,
  input  logic               out_stall_i
);

  localparam int unsigned NB = vps_pkg::DIV_BITS;
  localparam int unsigned CW = vps_pkg::CLIP_W;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [NB-1:0] sh;
    logic [NB-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]        lane;
    logic [CW-1:0]      d;
    logic signed [31:0] depth;
    logic               w_zero;
  } stage_t;

  stage_t    st_q [NB+1];
  logic      sv_q [NB+1];
  stage_t    st0_d;
  logic      adv;
  vps_pkg::out_item_t out_d;
  logic      out_valid_q;
  vps_pkg::out_item_t out_q;

  function automatic lane_t lane_init(logic [vps_pkg::N_W-1:0] n, logic [CW-1:0] d,
                                      logic neg);
    lane_t l;
    logic [CW-1:0] hi;
    hi     = {1'b0, n[vps_pkg::N_W-1:16]};
    l.ovf  = (hi >= d);
    l.rem  = l.ovf ? '0 : hi;
    l.sh   = {n[15:0], 15'b0};
    l.q    = '0;
    l.neg  = neg;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [CW-1:0] d);
    lane_t r;
    logic [CW:0] t;
    logic        ge;
    t     = {l.rem, l.sh[NB-1]};
    ge    = (t >= {1'b0, d});
    r     = l;
    r.rem = ge ? CW'(t - {1'b0, d}) : t[CW-1:0];
    r.sh  = {l.sh[NB-2:0], 1'b0};
    r.q   = {l.q[NB-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [31:0] lane_result(lane_t l);
    logic signed [31:0] r;
    if (l.neg) begin
      r = l.ovf ? 32'sh80000000 : -$signed({1'b0, l.q});
    end else begin
      r = l.ovf ? 32'sh7fffffff : $signed({1'b0, l.q});
    end
    return r;
  endfunction

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  always_comb begin
    st0_d.lane[0] = lane_init(item_i.n_x, item_i.d, item_i.neg_x);
    st0_d.lane[1] = lane_init(item_i.n_y, item_i.d, item_i.neg_y);
    st0_d.d       = item_i.d;
    st0_d.depth   = item_i.depth;
    st0_d.w_zero  = item_i.w_zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= st0_d;
      for (int s = 1; s <= NB; s++) begin
        st_q[s].lane[0] <= lane_step(st_q[s-1].lane[0], st_q[s-1].d);
        st_q[s].lane[1] <= lane_step(st_q[s-1].lane[1], st_q[s-1].d);
        st_q[s].d       <= st_q[s-1].d;
        st_q[s].depth   <= st_q[s-1].depth;
        st_q[s].w_zero  <= st_q[s-1].w_zero;
      end
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NB; s++) begin
        sv_q[s] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= !empty_i;
      for (int s = 1; s <= NB; s++) begin
        sv_q[s] <= sv_q[s-1];
      end
      out_valid_q <= sv_q[NB];
    end
  end

  always_comb begin
    logic signed [31:0] sx, sy;
    sx = lane_result(st_q[NB].lane[0]);
    sy = lane_result(st_q[NB].lane[1]);
    if (st_q[NB].w_zero) begin
      sx = '0;
      sy = '0;
    end
    out_d.screen_x  = sx;
    out_d.screen_y  = sy;
    out_d.depth     = st_q[NB].depth;
    out_d.w_zero    = st_q[NB].w_zero;
    out_d.on_screen = !st_q[NB].w_zero && (st_q[NB].depth > 0) &&
                      !sx[31] && ($unsigned(sx) < {2'b0, cfg_i.width, 16'b0}) &&
                      !sy[31] && ($unsigned(sy) < {2'b0, cfg_i.height, 16'b0});
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hw/rtl/vertex_project_screen_test.sv
// Top level of the vertex projection block: configuration registers, front,
// queue and back. Depends on vps_pkg, vps_front, vps_queue and vps_back.
`timescale 1ns / 1ps

// Usage:
// Points enter on the input channel (in_valid_i, in_i, in_stall_o) as signed
// Q16.16 x, y, z. Each transfer yields exactly one result on the output channel
// (out_valid_o, out_o, out_stall_i) in input order: screen x and y, depth and
// the on-screen and zero-w flags.
// The block accepts one point per cycle while the output is taken. With no
// stall, an input transfer reaches its valid result through these registers:
// the product stage registers the point at the transfer, then come the clip
// sums, the numerators, the queue write with the span multiply, one divider
// setup stage, 31 divider stages of one quotient bit each for both axes, and
// the output register. The divider pipeline sets the latency; the rate is
// one per cycle while the output is taken.
// When the receiver stalls, the back part and its divider freeze and the
// queue fills; once it is full the front stalls and in_stall_o rises. The user
// must write configuration through cfg_we_i, cfg_idx_i and cfg_data_i only
// while the block is idle; the block does not enforce it. Reset empties every
// stage and the queue, clears the matrix rows, sets the viewport to 640 by 480.
module vertex_project_screen_test #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vps_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [vps_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  vps_pkg::in_item_t             in_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output vps_pkg::out_item_t            out_o,
  input  logic                          out_stall_i
);

  vps_pkg::cfg_t  cfg_q;
  vps_pkg::work_t push_item, pop_item;
  logic           push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row    <= '0;
      cfg_q.width  <= 14'd640;
      cfg_q.height <= 14'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vps_pkg::REG_ROW_X:  cfg_q.row[0] <= cfg_data_i;
        vps_pkg::REG_ROW_Y:  cfg_q.row[1] <= cfg_data_i;
        vps_pkg::REG_ROW_Z:  cfg_q.row[2] <= cfg_data_i;
        vps_pkg::REG_ROW_W:  cfg_q.row[3] <= cfg_data_i;
        vps_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data_i[vps_pkg::SPAN_W-1:0];
        vps_pkg::REG_HEIGHT: cfg_q.height <= cfg_data_i[vps_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  vps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  vps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  vps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_wzero_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.w_zero) |->
      (out_o.screen_x == 0 && out_o.screen_y == 0 && !out_o.on_screen))
    else $error("zero w result carries nonzero coordinates");

  a_onscreen_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.on_screen) |->
      (out_o.depth > 0 && !out_o.screen_x[31] && !out_o.screen_y[31]))
    else $error("on-screen result with bad depth or negative coordinate");
`endif

endmodule

### tb/sv/vertex_project_screen_test_test.sv
// Testbench for the vertex projection block: drives points with random idling,
// predicts each projected result and compares it field by field.
// Depends on vps_pkg and vertex_project_screen_test.
`timescale 1ns / 1ps

module vertex_project_screen_test_test;

  localparam int LATENCY = 36;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [vps_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [vps_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  vps_pkg::in_item_t in_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  vps_pkg::out_item_t out_o;
  logic out_stall_i = 1'b0;

  logic [63:0] row_coefs [4];
  logic [13:0] vp_width;
  logic [13:0] vp_height;
  vps_pkg::out_item_t projected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  int hold_off = 0;
  int hold_starts = 0;
  int hold_seen = 0;

  vertex_project_screen_test u_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vertex_project_screen_test_test: FAIL");
      $finish;
    end
  end

  function automatic longint clip_of(logic [63:0] row, vps_pkg::in_item_t p);
    longint s;
    s = longint'($signed(row[15:0])) * longint'(p.point_x)
      + longint'($signed(row[31:16])) * longint'(p.point_y)
      + longint'($signed(row[47:32])) * longint'(p.point_z)
      + (longint'($signed(row[63:48])) <<< 28);
    return s >>> 12;
  endfunction

  function automatic longint scaled_ratio(longint num, logic [13:0] span, longint den);
    bit neg;
    logic [127:0] n;
    logic [127:0] q;
    neg = (num < 0) != (den < 0);
    n = 128'(num < 0 ? -num : num) * 128'(span);
    n = (n << 15) / 128'(den < 0 ? -den : den);
    q = (n > 128'h8000_0000) ? 128'h8000_0000 : n;
    if (neg) return -longint'(q);
    return (q > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
  endfunction

  function automatic vps_pkg::out_item_t project(vps_pkg::in_item_t p);
    vps_pkg::out_item_t r;
    longint cx, cy, cz, cw, sx, sy, dp;
    cx = clip_of(row_coefs[0], p);
    cy = clip_of(row_coefs[1], p);
    cz = clip_of(row_coefs[2], p);
    cw = clip_of(row_coefs[3], p);
    dp = cz > 64'sh7FFF_FFFF ? 64'sh7FFF_FFFF : (cz < -64'sh8000_0000 ? -64'sh8000_0000 : cz);
    r = '0;
    r.depth = 32'(dp);
    if (cw == 0) begin
      r.w_zero = 1'b1;
    end else begin
      sx = scaled_ratio(cx + cw, vp_width, cw);
      sy = scaled_ratio(cw - cy, vp_height, cw);
      r.screen_x = 32'(sx);
      r.screen_y = 32'(sy);
      r.on_screen = dp > 0 && sx >= 0 && sx < (longint'(vp_width) << 16)
                    && sy >= 0 && sy < (longint'(vp_height) << 16);
    end
    return r;
  endfunction

  task automatic write_reg(vps_pkg::reg_idx_e idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vps_pkg::REG_WIDTH: vp_width = value[13:0];
      vps_pkg::REG_HEIGHT: vp_height = value[13:0];
      default: row_coefs[2'(idx)] = value;
    endcase
  endtask

  task automatic send_point(vps_pkg::in_item_t p);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    projected_q.push_back(project(p));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (projected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(200)) - 100) <<< 12;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(8192)) - 4096);
      2: return 16'h1000;
      default: return 16'h0;
    endcase
  endfunction

  task automatic random_matrix();
    logic [63:0] r;
    for (int i = 0; i < 4; i++) begin
      r = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      if (i == 3 && $urandom_range(3) != 0) r = {16'h1000, 16'h0, rand_coef(), 16'h0};
      write_reg(vps_pkg::reg_idx_e'(i), r);
    end
  endtask

  task automatic test_reset_matrix();
    send_point('{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0001_0000});
    drain();
  endtask

  task automatic test_directed();
    write_reg(vps_pkg::REG_ROW_X, {16'h0, 16'h0, 16'h0, 16'h1000});
    write_reg(vps_pkg::REG_ROW_Y, {16'h0, 16'h0, 16'h1000, 16'h0});
    write_reg(vps_pkg::REG_ROW_Z, {16'h1000, 16'h0, 16'h0, 16'h0});
    write_reg(vps_pkg::REG_ROW_W, {16'h0, 16'h1000, 16'h0, 16'h0});
    send_point('{32'sh0, 32'sh0, 32'sh0001_0000});
    send_point('{32'sh0000_8000, -32'sh0000_8000, 32'sh0001_0000});
    send_point('{32'sh0, 32'sh0, 32'sh0});
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001});
    send_point('{-32'sh8000_0000, -32'sh8000_0000, 32'shFFFF_FFFF});
    send_point('{32'sh0001_0000, 32'sh0, -32'sh0001_0000});
    send_point('{-32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    drain();
    write_reg(vps_pkg::REG_ROW_X, {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(vps_pkg::REG_ROW_Z, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(vps_pkg::REG_WIDTH, 64'h3FFF);
    write_reg(vps_pkg::REG_HEIGHT, 64'h1);
    send_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0001_0000});
    send_point('{-32'sh8000_0000, 32'sh0001_0000, 32'sh0000_1000});
    send_point('{32'sh0000_0001, 32'sh0, 32'sh0000_0010});
    drain();
    write_reg(vps_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_C000);
    write_reg(vps_pkg::REG_HEIGHT, 64'h0);
    send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    send_point('{32'sh0, 32'sh0, -32'sh0001_0000});
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      random_matrix();
      case (ph % 4)
        0: begin
          write_reg(vps_pkg::REG_WIDTH, 64'd640);
          write_reg(vps_pkg::REG_HEIGHT, 64'd480);
        end
        1: begin
          write_reg(vps_pkg::REG_WIDTH, 64'd1);
          write_reg(vps_pkg::REG_HEIGHT, 64'h3FFF);
        end
        default: begin
          write_reg(vps_pkg::REG_WIDTH, 64'($urandom_range(16383, 1)));
          write_reg(vps_pkg::REG_HEIGHT, 64'($urandom_range(16383, 1)));
        end
      endcase
      calm = (ph == 2);
      for (int i = 0; i < per_phase; i++)
        send_point('{rand_coord(), rand_coord(), rand_coord()});
      calm = 1'b0;
      drain();
    end
  endtask

  task automatic test_back_pressure();
    hold_starts++;
    for (int i = 0; i < 60; i++) send_point('{rand_coord(), rand_coord(), rand_coord()});
    drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_starts) begin
      hold_seen <= hold_starts;
      hold_off <= 199;
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && $urandom_range(99) < 15;
    end
  end

  always @(posedge clk_i) begin
    vps_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (projected_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = projected_q.pop_front();
        if (out_o.screen_x !== want.screen_x) begin
          $error("screen_x expected %0d actual %0d", want.screen_x, out_o.screen_x);
          errors++;
        end
        if (out_o.screen_y !== want.screen_y) begin
          $error("screen_y expected %0d actual %0d", want.screen_y, out_o.screen_y);
          errors++;
        end
        if (out_o.depth !== want.depth) begin
          $error("depth expected %0d actual %0d", want.depth, out_o.depth);
          errors++;
        end
        if (out_o.on_screen !== want.on_screen) begin
          $error("on_screen expected %0b actual %0b", want.on_screen, out_o.on_screen);
          errors++;
        end
        if (out_o.w_zero !== want.w_zero) begin
          $error("w_zero expected %0b actual %0b", want.w_zero, out_o.w_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    row_coefs = '{default: '0};
    vp_width = 14'd640;
    vp_height = 14'd480;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_matrix();
    test_directed();
    test_back_pressure();
    test_random(10, 125);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0 && projected_q.size() == 0) begin
      $display("vertex_project_screen_test_test: PASS");
    end else begin
      $display("vertex_project_screen_test_test: FAIL");
    end
    $finish;
  end

endmodule
